// ----- src/tef_pkg.sv -----
package tef_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_MOTION_THR  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PROX_THR    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LOCK_TMO    = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_STREAK_MIN  = 2'd3;

  localparam logic [15:0] MOTION_THR_RST = 16'd1500;
  localparam logic [15:0] PROX_THR_RST   = 16'd500;
  localparam logic [31:0] LOCK_TMO_RST   = 32'd5000;
  localparam logic [3:0]  STREAK_MIN_RST = 4'd2;

  localparam logic [3:0]  STREAK_MAX = 4'd15;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_ALERT = 3'b010,
    MODE_LOCK  = 3'b100
  } mode_e;

  typedef enum logic [1:0] {
    DEC_NONE  = 2'd0,
    DEC_ALERT = 2'd1,
    DEC_LOCK  = 2'd2
  } dec_e;

  typedef struct packed {
    logic [15:0] motion_thr;
    logic [15:0] prox_thr;
    logic [31:0] lock_tmo;
    logic [3:0]  streak_min;
  } cfg_t;

  typedef struct packed {
    logic [15:0] motion_mg;
    logic [15:0] range_mm;
    logic        anomaly_sustained;
    logic [31:0] now_tick;
  } sample_t;

endpackage

// ----- src/threat_escalation_fsm_top.sv -----
// The accepted item is registered in s1_q; its decision is registered in dec_q when it advances.
// Throughput: one item per cycle while the output is not stalled; the core state updates per advance.
// The input stage stalls only while the output register holds an untaken item.
// Reset (async, active low) clears the valid flags of both stages, puts the mode in idle
// with a zero entry tick and streak, and loads the configuration registers with defaults.
module threat_escalation_fsm_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tef_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tef_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [15:0]                   motion_mg_i,
  input  logic [15:0]                   range_mm_i,
  input  logic                          anomaly_sustained_i,
  input  logic [31:0]                   now_tick_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    decision_o
);

  tef_pkg::cfg_t    cfg;
  tef_pkg::sample_t s1_q;
  tef_pkg::dec_e    dec_d, dec_q;
  logic             s1_valid_q, s1_valid_d;
  logic             out_valid_q, out_valid_d;
  logic             in_acc, out_adv;

  assign out_adv    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !out_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  tef_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  tef_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (out_adv),
    .cfg_i    (cfg),
    .sample_i (s1_q),
    .dec_o    (dec_d)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (out_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.motion_mg         <= motion_mg_i;
      s1_q.range_mm          <= range_mm_i;
      s1_q.anomaly_sustained <= anomaly_sustained_i;
      s1_q.now_tick          <= now_tick_i;
    end
    if (out_adv) begin
      dec_q <= dec_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign decision_o  = dec_q;

endmodule

// ----- src/tef_cfg_regs.sv -----
module tef_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tef_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tef_pkg::CfgDataW-1:0]  cfg_data_i,
  output tef_pkg::cfg_t                 cfg_o
);

  tef_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tef_pkg::CFG_MOTION_THR: cfg_d.motion_thr = cfg_data_i[15:0];
        tef_pkg::CFG_PROX_THR:   cfg_d.prox_thr   = cfg_data_i[15:0];
        tef_pkg::CFG_LOCK_TMO:   cfg_d.lock_tmo   = cfg_data_i[31:0];
        tef_pkg::CFG_STREAK_MIN: cfg_d.streak_min = cfg_data_i[3:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.motion_thr <= tef_pkg::MOTION_THR_RST;
      cfg_q.prox_thr   <= tef_pkg::PROX_THR_RST;
      cfg_q.lock_tmo   <= tef_pkg::LOCK_TMO_RST;
      cfg_q.streak_min <= tef_pkg::STREAK_MIN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/tef_core.sv -----
module tef_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  tef_pkg::cfg_t     cfg_i,
  input  tef_pkg::sample_t  sample_i,
  output tef_pkg::dec_e     dec_o
);

  tef_pkg::mode_e mode_q, mode_d;
  logic [31:0]    enter_q, enter_d;
  logic [3:0]     streak_q, streak_d;

  logic        motion, near, anom, dual, supported;
  logic [31:0] elapsed;
  logic [3:0]  streak_up;

  assign motion    = sample_i.motion_mg > cfg_i.motion_thr;
  assign near      = (sample_i.range_mm != 16'd0) &&
                     (sample_i.range_mm < cfg_i.prox_thr);
  assign anom      = sample_i.anomaly_sustained;
  assign dual      = motion && near;
  assign supported = anom && (motion || near);
  assign elapsed   = sample_i.now_tick - enter_q;
  assign streak_up = (streak_q == tef_pkg::STREAK_MAX) ? streak_q : streak_q + 4'd1;

  always_comb begin
    mode_d   = mode_q;
    enter_d  = enter_q;
    streak_d = streak_q;
    dec_o    = tef_pkg::DEC_NONE;
    case (mode_q)
      tef_pkg::MODE_IDLE: begin
        if (motion || near || anom) begin
          mode_d   = tef_pkg::MODE_ALERT;
          enter_d  = sample_i.now_tick;
          streak_d = 4'd0;
          dec_o    = tef_pkg::DEC_ALERT;
        end
      end
      tef_pkg::MODE_ALERT: begin
        if (dual || supported) begin
          streak_d = anom ? streak_up : 4'd0;
          if (dual || (streak_d >= cfg_i.streak_min)) begin
            mode_d  = tef_pkg::MODE_LOCK;
            enter_d = sample_i.now_tick;
            dec_o   = tef_pkg::DEC_LOCK;
          end else begin
            dec_o = tef_pkg::DEC_ALERT;
          end
        end else if (!motion && !near && !anom) begin
          mode_d   = tef_pkg::MODE_IDLE;
          enter_d  = sample_i.now_tick;
          streak_d = 4'd0;
        end else begin
          streak_d = 4'd0;
          dec_o    = tef_pkg::DEC_ALERT;
        end
      end
      tef_pkg::MODE_LOCK: begin
        if (elapsed > cfg_i.lock_tmo) begin
          mode_d  = tef_pkg::MODE_IDLE;
          enter_d = sample_i.now_tick;
        end else begin
          dec_o = tef_pkg::DEC_LOCK;
        end
      end
      default: mode_d = tef_pkg::MODE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= tef_pkg::MODE_IDLE;
      enter_q  <= 32'd0;
      streak_q <= 4'd0;
    end else if (fire_i) begin
      mode_q   <= mode_d;
      enter_q  <= enter_d;
      streak_q <= streak_d;
    end
  end

endmodule

// ----- src/tef_checker.sv -----
module tef_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [1:0]                    decision_o
);

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(decision_o))
    else $error("stalled decision changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  a_dec_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> decision_o != 2'd3)
    else $error("invalid decision code");

endmodule

bind threat_escalation_fsm_top tef_checker u_tef_checker (.*);
